// ----- hdl/rrs_pkg.sv -----
`default_nettype none
package rrs_pkg;

  localparam int ACTION_W = 2;
  localparam int SLICE_W  = 16;

  localparam logic [ACTION_W-1:0] ACT_ADD   = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_LEAVE = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_TICK  = 2'd2;

  localparam logic [SLICE_W-1:0] SLICE_RESET = 16'd1;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } ctrl_state_t;

  typedef struct packed {
    logic load;
    logic exec;
  } ctrl_cmd_t;

endpackage
`default_nettype wire

// ----- hdl/round_robin_thread_scheduler_top.sv -----
// An accepted event is loaded in the idle state, applied in the execute state, and its result is registered.
// No new event is taken while busy in the execute state; the ready-queue read is registered at load.
// The receiver cannot stall; each result is valid for exactly one cycle.
// Synchronous active-low reset empties the queue, idles the CPU and sets the slice to 1.
`default_nettype none
module round_robin_thread_scheduler_top
  import rrs_pkg::*;
#(
  parameter int QUEUE_DEPTH = 256,
  parameter int ID_BITS     = 8
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic [ACTION_W-1:0]                 in_action,
  input  wire logic [ID_BITS-1:0]                  in_thread_id,
  output logic                                     out_valid,
  output logic                                     out_running_valid,
  output logic [ID_BITS-1:0]                       out_running_thread,
  output logic                                     out_queue_overflow,
  output logic [$clog2(QUEUE_DEPTH + 1)-1:0]       out_ready_count,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [SLICE_W-1:0]                  cfg_time_slice
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  ctrl_cmd_t cmd;

  assign cfg_ready = 1'b1;

  rrs_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  rrs_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ID_BITS     (ID_BITS)
  ) u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .in_action          (in_action),
    .in_thread_id       (in_thread_id),
    .cfg_valid          (cfg_valid && cfg_ready),
    .cfg_time_slice     (cfg_time_slice),
    .out_valid          (out_valid),
    .out_running_valid  (out_running_valid),
    .out_running_thread (out_running_thread),
    .out_queue_overflow (out_queue_overflow),
    .out_ready_count    (out_ready_count)
  );

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after an accepted transaction");

  a_result_timing: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 2))
    else $error("result strobe without a matching accepted transaction");

  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_running_valid) |-> (out_running_thread == '0))
    else $error("idle result carries a nonzero thread id");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_ready_count <= CNT_W'(QUEUE_DEPTH)))
    else $error("ready count exceeds queue depth");

endmodule
`default_nettype wire

// ----- hdl/rrs_ctrl.sv -----
`default_nettype none
module rrs_ctrl
  import rrs_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  output logic      busy,
  output ctrl_cmd_t cmd
);

  ctrl_state_t state_r;
  ctrl_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    busy      = 1'b0;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        busy      = 1'b1;
        cmd.exec  = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- hdl/rrs_datapath.sv -----
`default_nettype none
module rrs_datapath
  import rrs_pkg::*;
#(
  parameter int QUEUE_DEPTH = 256,
  parameter int ID_BITS     = 8,
  parameter int PTR_W       = $clog2(QUEUE_DEPTH),
  parameter int CNT_W       = $clog2(QUEUE_DEPTH + 1)
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire ctrl_cmd_t           cmd,
  input  wire logic [ACTION_W-1:0] in_action,
  input  wire logic [ID_BITS-1:0]  in_thread_id,
  input  wire logic                cfg_valid,
  input  wire logic [SLICE_W-1:0]  cfg_time_slice,
  output logic                     out_valid,
  output logic                     out_running_valid,
  output logic [ID_BITS-1:0]       out_running_thread,
  output logic                     out_queue_overflow,
  output logic [CNT_W-1:0]         out_ready_count
);

  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

  logic [ID_BITS-1:0]  mem [QUEUE_DEPTH];
  logic [ID_BITS-1:0]  rd_data_r;

  logic [ACTION_W-1:0] action_r;
  logic [ID_BITS-1:0]  id_r;
  logic [SLICE_W-1:0]  slice_r;

  logic [PTR_W-1:0]    head_r, head_nxt;
  logic [PTR_W-1:0]    tail_r, tail_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [ID_BITS-1:0]  running_r, running_nxt;
  logic                cpu_busy_r, cpu_busy_nxt;
  logic [SLICE_W-1:0]  elapsed_r, elapsed_nxt;
  logic [SLICE_W-1:0]  elapsed_inc;
  logic                overflow;
  logic                wr_en;
  logic [ID_BITS-1:0]  wr_data;

  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
    ring_next = (p == LAST_PTR) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[tail_r] <= wr_data;
    end
    if (cmd.load) begin
      rd_data_r <= mem[head_r];
      action_r  <= in_action;
      id_r      <= in_thread_id;
    end
  end

  assign elapsed_inc = elapsed_r + 1'b1;

  always_comb begin
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    count_nxt    = count_r;
    running_nxt  = running_r;
    cpu_busy_nxt = cpu_busy_r;
    elapsed_nxt  = elapsed_r;
    overflow     = 1'b0;
    wr_en        = 1'b0;
    wr_data      = id_r;
    case (action_r)
      ACT_ADD: begin
        if (!cpu_busy_r) begin
          running_nxt  = id_r;
          cpu_busy_nxt = 1'b1;
        end else if (count_r == FULL_CNT) begin
          overflow = 1'b1;
        end else begin
          wr_en     = 1'b1;
          tail_nxt  = ring_next(tail_r);
          count_nxt = count_r + 1'b1;
        end
      end
      ACT_LEAVE: begin
        elapsed_nxt = '0;
        if (count_r == '0) begin
          cpu_busy_nxt = 1'b0;
          running_nxt  = '0;
        end else begin
          running_nxt  = rd_data_r;
          head_nxt     = ring_next(head_r);
          count_nxt    = count_r - 1'b1;
          cpu_busy_nxt = 1'b1;
        end
      end
      ACT_TICK: begin
        if (cpu_busy_r) begin
          elapsed_nxt = elapsed_inc;
          if (elapsed_inc >= slice_r) begin
            elapsed_nxt = '0;
            wr_data     = running_r;
            if (count_r == '0) begin
              // The running thread keeps the CPU: both queue pointers advance together and nothing is written.
              tail_nxt = ring_next(tail_r);
              head_nxt = ring_next(head_r);
            end else if (count_r == FULL_CNT) begin
              overflow    = 1'b1;
              running_nxt = rd_data_r;
              head_nxt    = ring_next(head_r);
              count_nxt   = count_r - 1'b1;
            end else begin
              wr_en       = 1'b1;
              running_nxt = rd_data_r;
              tail_nxt    = ring_next(tail_r);
              head_nxt    = ring_next(head_r);
            end
          end
        end
      end
      default: begin
      end
    endcase
    if (!cmd.exec) begin
      wr_en = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r     <= '0;
      tail_r     <= '0;
      count_r    <= '0;
      running_r  <= '0;
      cpu_busy_r <= 1'b0;
      elapsed_r  <= '0;
      slice_r    <= SLICE_RESET;
      out_valid  <= 1'b0;
    end else begin
      out_valid <= cmd.exec;
      if (cfg_valid) begin
        slice_r <= cfg_time_slice;
      end
      if (cmd.exec) begin
        head_r     <= head_nxt;
        tail_r     <= tail_nxt;
        count_r    <= count_nxt;
        running_r  <= running_nxt;
        cpu_busy_r <= cpu_busy_nxt;
        elapsed_r  <= elapsed_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      out_running_valid  <= cpu_busy_nxt;
      out_running_thread <= cpu_busy_nxt ? running_nxt : '0;
      out_queue_overflow <= overflow;
      out_ready_count    <= count_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- tb/tb_round_robin_thread_scheduler_top.sv -----
module tb_round_robin_thread_scheduler_top;
  import rrs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int QDEPTH  = 256;
  localparam int IDW     = 8;
  localparam int CNTW    = $clog2(QDEPTH + 1);
  localparam logic [ACTION_W-1:0] ACT_UNKNOWN = 2'd3;

  typedef struct packed {
    logic            running_valid;
    logic [IDW-1:0]  running_thread;
    logic            queue_overflow;
    logic [CNTW-1:0] ready_count;
  } sched_status_t;

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic [ACTION_W-1:0] in_action;
  logic [IDW-1:0]      in_thread_id;
  logic                out_valid;
  logic                out_running_valid;
  logic [IDW-1:0]      out_running_thread;
  logic                out_queue_overflow;
  logic [CNTW-1:0]     out_ready_count;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [SLICE_W-1:0]  cfg_time_slice;

  round_robin_thread_scheduler_top #(
    .QUEUE_DEPTH(QDEPTH),
    .ID_BITS    (IDW)
  ) u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_action         (in_action),
    .in_thread_id      (in_thread_id),
    .out_valid         (out_valid),
    .out_running_valid (out_running_valid),
    .out_running_thread(out_running_thread),
    .out_queue_overflow(out_queue_overflow),
    .out_ready_count   (out_ready_count),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_time_slice    (cfg_time_slice)
  );

  logic [IDW-1:0]     ready_mem [QDEPTH];
  logic [IDW-1:0]     ready_head;
  logic [IDW-1:0]     ready_tail;
  logic [CNTW-1:0]    ready_cnt;
  logic [IDW-1:0]     run_id;
  logic               cpu_on;
  logic [SLICE_W-1:0] tick_cnt;
  logic [SLICE_W-1:0] slice_len;

  sched_status_t status_q[$];
  sched_status_t want_st;
  int            err_cnt;
  bit            gaps_on;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("FAIL round_robin_thread_scheduler_top");
    $finish;
  end

  function automatic logic ready_push(input logic [IDW-1:0] id);
    if (ready_cnt >= QDEPTH) begin
      return 1'b1;
    end
    ready_mem[ready_tail] = id;
    ready_tail = ready_tail + 1'b1;
    ready_cnt = ready_cnt + 1'b1;
    return 1'b0;
  endfunction

  function automatic void dispatch_head();
    tick_cnt = '0;
    if (ready_cnt == 0) begin
      cpu_on = 1'b0;
      run_id = '0;
    end else begin
      run_id = ready_mem[ready_head];
      ready_head = ready_head + 1'b1;
      ready_cnt = ready_cnt - 1'b1;
      cpu_on = 1'b1;
    end
  endfunction

  function automatic sched_status_t schedule_event(input logic [ACTION_W-1:0] act,
                                                   input logic [IDW-1:0] id);
    sched_status_t st;
    logic          ovf;
    ovf = 1'b0;
    case (act)
      ACT_ADD: begin
        if (!cpu_on) begin
          run_id = id;
          cpu_on = 1'b1;
        end else begin
          ovf = ready_push(id);
        end
      end
      ACT_LEAVE: begin
        dispatch_head();
      end
      ACT_TICK: begin
        if (cpu_on) begin
          tick_cnt = tick_cnt + 1'b1;
          if (tick_cnt >= slice_len) begin
            ovf = ready_push(run_id);
            dispatch_head();
          end
        end
      end
      default: begin
      end
    endcase
    st.running_valid  = cpu_on;
    st.running_thread = cpu_on ? run_id : '0;
    st.queue_overflow = ovf;
    st.ready_count    = ready_cnt;
    return st;
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t ERROR %s: expected %0d, actual %0d", $time, name, want, got);
      err_cnt++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (status_q.size() == 0) begin
        $display("%0t ERROR unexpected transaction: expected none, actual %0d/%0d/%0d/%0d",
                 $time, out_running_valid, out_running_thread, out_queue_overflow,
                 out_ready_count);
        err_cnt++;
      end else begin
        want_st = status_q.pop_front();
        check_field("running_valid", want_st.running_valid, out_running_valid);
        check_field("running_thread", want_st.running_thread, out_running_thread);
        check_field("queue_overflow", want_st.queue_overflow, out_queue_overflow);
        check_field("ready_count", want_st.ready_count, out_ready_count);
      end
    end
  end

  function automatic int pick_gap();
    if (!gaps_on) begin
      return 0;
    end
    if ($urandom_range(0, 9) == 0) begin
      return $urandom_range(5, 30);
    end
    return $urandom_range(0, 2);
  endfunction

  task automatic send_event(input logic [ACTION_W-1:0] act, input logic [IDW-1:0] id);
    int n;
    n = pick_gap();
    if (n > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
    @(negedge clk);
    start        <= 1'b1;
    in_action    <= act;
    in_thread_id <= id;
    @(posedge clk);
    while (busy) @(posedge clk);
    status_q.push_back(schedule_event(act, id));
  endtask

  task automatic drain_results();
    @(negedge clk);
    start <= 1'b0;
    while (status_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_slice(input logic [SLICE_W-1:0] value);
    drain_results();
    cfg_valid      <= 1'b1;
    cfg_time_slice <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    slice_len = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_random(input int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 42) begin
        send_event(ACT_ADD, IDW'($urandom_range(0, 255)));
      end else if (r < 67) begin
        send_event(ACT_LEAVE, IDW'($urandom_range(0, 255)));
      end else if (r < 95) begin
        send_event(ACT_TICK, IDW'($urandom_range(0, 255)));
      end else begin
        send_event(ACT_UNKNOWN, IDW'($urandom_range(0, 255)));
      end
    end
  endtask

  task automatic test_directed_events();
    send_event(ACT_TICK, 8'h00);
    send_event(ACT_LEAVE, 8'hFF);
    send_event(ACT_UNKNOWN, 8'hFF);
    send_event(ACT_ADD, 8'hFF);
    send_event(ACT_ADD, 8'h00);
    send_event(ACT_ADD, 8'hA5);
    send_event(ACT_TICK, 8'h00);
    send_event(ACT_UNKNOWN, 8'h5A);
    send_event(ACT_LEAVE, 8'h00);
    send_event(ACT_LEAVE, 8'h00);
    send_event(ACT_LEAVE, 8'h00);
    send_event(ACT_LEAVE, 8'h00);
    write_slice(16'd3);
    send_event(ACT_ADD, 8'h5A);
    send_event(ACT_ADD, 8'h3C);
    send_event(ACT_TICK, 8'h00);
    send_event(ACT_TICK, 8'h00);
    send_event(ACT_LEAVE, 8'h00);
    send_event(ACT_TICK, 8'h00);
    send_event(ACT_TICK, 8'h00);
    send_event(ACT_TICK, 8'h00);
  endtask

  task automatic test_slice_extremes();
    write_slice(16'd0);
    send_event(ACT_TICK, 8'h00);
    send_event(ACT_ADD, 8'h81);
    send_event(ACT_TICK, 8'h00);
    send_event(ACT_TICK, 8'h00);
    send_event(ACT_LEAVE, 8'h00);
    write_slice(16'hFFFF);
    send_event(ACT_TICK, 8'h00);
    send_event(ACT_ADD, 8'h7E);
    send_event(ACT_TICK, 8'h00);
    send_event(ACT_TICK, 8'h00);
    send_event(ACT_LEAVE, 8'h00);
  endtask

  task automatic test_queue_full();
    int fill;
    write_slice(16'd1);
    fill = QDEPTH - int'(ready_cnt) + (cpu_on ? 0 : 1) + 3;
    for (int i = 0; i < fill; i++) begin
      send_event(ACT_ADD, IDW'($urandom_range(0, 255)));
    end
    send_event(ACT_TICK, 8'h00);
    send_event(ACT_ADD, 8'hC3);
    send_event(ACT_ADD, 8'h3C);
    send_event(ACT_TICK, 8'h00);
    send_event(ACT_TICK, 8'h00);
  endtask

  task automatic test_sender_pause();
    write_slice(16'd2);
    send_random(20);
    drain_results();
    send_random(20);
  endtask

  task automatic test_random_traffic();
    write_slice(16'd2);
    send_random(30);
    gaps_on = 1'b0;
    write_slice(SLICE_W'($urandom_range(1, 6)));
    send_random(30);
    gaps_on = 1'b1;
    write_slice(16'd1);
    send_random(20);
    write_slice(SLICE_W'($urandom_range(0, 65535)));
    send_random(15);
    write_slice(SLICE_W'($urandom_range(3, 10)));
    send_random(20);
  endtask

  initial begin
    rst_n          = 1'b0;
    start          = 1'b0;
    in_action      = ACT_ADD;
    in_thread_id   = '0;
    cfg_valid      = 1'b0;
    cfg_time_slice = SLICE_RESET;
    ready_head     = '0;
    ready_tail     = '0;
    ready_cnt      = '0;
    run_id         = '0;
    cpu_on         = 1'b0;
    tick_cnt       = '0;
    slice_len      = SLICE_RESET;
    err_cnt        = 0;
    gaps_on        = 1'b1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_events();
    test_slice_extremes();
    test_queue_full();
    test_sender_pause();
    test_random_traffic();

    drain_results();
    repeat (8) @(posedge clk);
    if (err_cnt == 0) begin
      $display("PASS round_robin_thread_scheduler_top");
    end else begin
      $display("FAIL round_robin_thread_scheduler_top");
    end
    $finish;
  end

endmodule
